// File: hdl/mi3_pkg.sv
package mi3_pkg;

   // field widths
   localparam int ELEM_W = 32;
   localparam int THR_W  = 16;
   localparam int Q_W    = 32;

   // internal widths: exact products, cofactors, determinant terms
   localparam int PROD_W = 2 * ELEM_W;
   localparam int ADJ_W  = PROD_W + 1;
   localparam int PART_W = ELEM_W + ADJ_W - Q_W;
   localparam int TERM_W = ELEM_W + ADJ_W;
   localparam int DMAG_W = TERM_W - 1;
   localparam int REM_W  = DMAG_W + Q_W + 2;

   // element counts
   localparam int N_ELEM = 9;
   localparam int N_TERM = 3;

   // pipeline depth
   localparam int DET_STAGES  = 6;
   localparam int LANE_STAGES = Q_W + 3;
   localparam int PIPE_STAGES = DET_STAGES + LANE_STAGES;

   // cofactor j is a[P]*a[Q] - a[R]*a[S], sign already folded in
   localparam int COF_P [N_ELEM] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
   localparam int COF_Q [N_ELEM] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
   localparam int COF_R [N_ELEM] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
   localparam int COF_S [N_ELEM] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

   // fixed point constants
   localparam logic [Q_W-1:0] ONE_Q16 = 32'h0001_0000;
   localparam logic [Q_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [Q_W-1:0] SAT_NEG = 32'h8000_0000;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [ADJ_W-1:0]  adj_type;

   typedef struct packed {
      logic [DMAG_W-1:0] dmag;
      logic              dneg;
   } det_type;

   typedef struct packed {
      logic [Q_W-1:0] quo;
      logic           ovf;
      logic           neg;
   } lane_type;

endpackage

// File: hdl/mi3_det.sv
module mi3_det import mi3_pkg::*; (
   input  logic             clock,
   input  logic             adv,
   input  elem_type         a_in [N_ELEM],
   input  logic [THR_W-1:0] threshold,
   output adj_type          adj_out [N_ELEM],
   output det_type          det_out,
   output logic             singular_out
);

   logic signed [PROD_W-1:0] pq_ff [N_ELEM];
   logic signed [PROD_W-1:0] rs_ff [N_ELEM];
   elem_type                 row_s1_ff [N_TERM];
   elem_type                 row_s2_ff [N_TERM];
   adj_type                  adj_s2_ff [N_ELEM];
   adj_type                  adj_s3_ff [N_ELEM];
   adj_type                  adj_s4_ff [N_ELEM];
   adj_type                  adj_s5_ff [N_ELEM];
   adj_type                  adj_s6_ff [N_ELEM];
   logic signed [PART_W-1:0] ph_ff [N_TERM];
   logic signed [PART_W-1:0] pl_ff [N_TERM];
   logic signed [TERM_W-1:0] term_ff [N_TERM];
   logic signed [TERM_W-1:0] det_s5_ff;
   logic signed [TERM_W-1:0] det_abs;
   det_type                  det_s6_ff;
   logic                     singular_s7_ff;
   logic [DMAG_W-1:0]        thr_q;

   // magnitude of the determinant and threshold in the same scale
   always_comb begin
      det_abs = det_s5_ff[TERM_W-1] ? -det_s5_ff : det_s5_ff;
      thr_q   = DMAG_W'({threshold, 32'b0});
   end

   // products, cofactors, split terms, determinant, magnitude, singular test
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < N_ELEM; j++) begin
            pq_ff[j]     <= PROD_W'(a_in[COF_P[j]] * a_in[COF_Q[j]]);
            rs_ff[j]     <= PROD_W'(a_in[COF_R[j]] * a_in[COF_S[j]]);
            adj_s2_ff[j] <= ADJ_W'(pq_ff[j]) - ADJ_W'(rs_ff[j]);
         end
         for (int k = 0; k < N_TERM; k++) begin
            row_s1_ff[k] <= a_in[k];
            row_s2_ff[k] <= row_s1_ff[k];
            ph_ff[k]     <= PART_W'(row_s2_ff[k] *
                                    $signed(adj_s2_ff[3*k][ADJ_W-1:Q_W]));
            pl_ff[k]     <= PART_W'(row_s2_ff[k] *
                                    $signed({1'b0, adj_s2_ff[3*k][Q_W-1:0]}));
            term_ff[k]   <= (TERM_W'(ph_ff[k]) <<< Q_W) + TERM_W'(pl_ff[k]);
         end
         adj_s3_ff      <= adj_s2_ff;
         adj_s4_ff      <= adj_s3_ff;
         adj_s5_ff      <= adj_s4_ff;
         adj_s6_ff      <= adj_s5_ff;
         det_s5_ff      <= term_ff[0] + term_ff[1] + term_ff[2];
         det_s6_ff.dneg <= det_s5_ff[TERM_W-1];
         det_s6_ff.dmag <= DMAG_W'(det_abs);
         singular_s7_ff <= (det_s6_ff.dmag == '0) || (det_s6_ff.dmag < thr_q);
      end
   end

   assign adj_out      = adj_s6_ff;
   assign det_out      = det_s6_ff;
   assign singular_out = singular_s7_ff;

endmodule

// File: hdl/mi3_lane.sv
module mi3_lane import mi3_pkg::*; (
   input  logic     clock,
   input  logic     adv,
   input  adj_type  adj_in,
   input  det_type  det_in,
   output lane_type res_out
);

   logic [ADJ_W-1:0]  adj_abs;
   logic [ADJ_W-2:0]  amag_ff;
   logic [DMAG_W-1:0] d0_ff;
   logic [DMAG_W-1:0] d1_ff;
   logic              neg0_ff;
   logic              neg1_ff;
   logic [REM_W-1:0]  num_ff;
   logic [REM_W-1:0]  rem_ff [0:Q_W-1];
   logic [DMAG_W-1:0] dv_ff  [0:Q_W-1];
   logic              neg_ff [0:Q_W];
   logic              ovf_ff [0:Q_W];
   logic [Q_W-1:0]    quo_ff [1:Q_W];
   logic [REM_W-1:0]  dsh    [1:Q_W];
   logic [Q_W:1]      fits;

   assign adj_abs = adj_in[ADJ_W-1] ? -adj_in : adj_in;

   // trial subtract of the doubled divisor, one quotient bit per stage
   always_comb begin
      for (int k = 1; k <= Q_W; k++) begin
         dsh[k]  = REM_W'(dv_ff[k-1]) << (Q_W + 1 - k);
         fits[k] = rem_ff[k-1] >= dsh[k];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // magnitude and result sign
         amag_ff <= adj_abs[ADJ_W-2:0];
         neg0_ff <= adj_in[ADJ_W-1] ^ det_in.dneg;
         d0_ff   <= det_in.dmag;
         // rounding numerator 2*|adj|*2^32 + |det|
         num_ff  <= (REM_W'(amag_ff) << (Q_W + 1)) + REM_W'(d0_ff);
         neg1_ff <= neg0_ff;
         d1_ff   <= d0_ff;
         // quotient of 2^32 or more saturates
         ovf_ff[0] <= num_ff >= (REM_W'(d1_ff) << (Q_W + 1));
         rem_ff[0] <= num_ff;
         dv_ff[0]  <= d1_ff;
         neg_ff[0] <= neg1_ff;
         // restoring steps
         for (int k = 1; k <= Q_W; k++) begin
            if (k < Q_W) begin
               rem_ff[k] <= fits[k] ? rem_ff[k-1] - dsh[k] : rem_ff[k-1];
               dv_ff[k]  <= dv_ff[k-1];
            end
            if (k == 1) begin
               quo_ff[k] <= {(Q_W-1)'(0), fits[k]};
            end else begin
               quo_ff[k] <= {quo_ff[k-1][Q_W-2:0], fits[k]};
            end
            neg_ff[k] <= neg_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign res_out.quo = quo_ff[Q_W];
   assign res_out.ovf = ovf_ff[Q_W];
   assign res_out.neg = neg_ff[Q_W];

endmodule

// File: hdl/matrix_inverse_3x3.sv
// 3x3 matrix inverse, signed Q16.16 in and out, adjugate over determinant.
// req channel: one beat is a whole matrix, a00..a22; it is taken at a clock
// edge with req_valid high and req_stall low.
// rsp channel: one beat per matrix, b00..b22 and rsp_singular, taken at an
// edge with rsp_valid high and rsp_stall low. Results keep input order.
// csr channel: csr_det_threshold is written when csr_valid is high; csr_ready
// is always high. Write it only while no matrix is in flight.
// A matrix whose |det| is below the threshold (or zero) returns the identity
// with rsp_singular set; otherwise each element is rounded and saturated.
// Pipeline: 6 determinant stages, then 35 stages of nine divider lanes (3 setup
// stages for the magnitude, rounding numerator and overflow test, then one
// quotient bit per stage), whose last stage loads the output register.
// Throughput: one matrix per cycle while the pipeline is not held.
// Stalls: an output register plus one skid entry; the whole pipeline holds
// only when both are full and rsp_stall is high, which raises req_stall.
// Reset: synchronous, clears all valid flags, threshold back to 1.
module matrix_inverse_3x3 import mi3_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [ELEM_W-1:0] req_a00,
   input  logic signed [ELEM_W-1:0] req_a01,
   input  logic signed [ELEM_W-1:0] req_a02,
   input  logic signed [ELEM_W-1:0] req_a10,
   input  logic signed [ELEM_W-1:0] req_a11,
   input  logic signed [ELEM_W-1:0] req_a12,
   input  logic signed [ELEM_W-1:0] req_a20,
   input  logic signed [ELEM_W-1:0] req_a21,
   input  logic signed [ELEM_W-1:0] req_a22,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [Q_W-1:0]    rsp_b00,
   output logic signed [Q_W-1:0]    rsp_b01,
   output logic signed [Q_W-1:0]    rsp_b02,
   output logic signed [Q_W-1:0]    rsp_b10,
   output logic signed [Q_W-1:0]    rsp_b11,
   output logic signed [Q_W-1:0]    rsp_b12,
   output logic signed [Q_W-1:0]    rsp_b20,
   output logic signed [Q_W-1:0]    rsp_b21,
   output logic signed [Q_W-1:0]    rsp_b22,
   output logic                     rsp_singular,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [THR_W-1:0]         csr_det_threshold
);

   logic [THR_W-1:0] thr_ff;
   logic             adv;
   logic             incoming;
   logic             pop;
   logic             vld_ff  [1:PIPE_STAGES];
   logic             sing_ff [DET_STAGES+2:PIPE_STAGES];
   elem_type         a_in    [N_ELEM];
   adj_type          adj_w   [N_ELEM];
   det_type          det_w;
   logic             det_sing;
   lane_type         lane_res [N_ELEM];
   logic [Q_W-1:0]   fin_b    [N_ELEM];
   logic [Q_W-1:0]   out_b_ff [N_ELEM];
   logic [Q_W-1:0]   skid_b_ff [N_ELEM];
   logic             out_sing_ff;
   logic             skid_sing_ff;
   logic             out_vld_ff;
   logic             skid_vld_ff;

   // threshold register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_W'(1);
      end else if (csr_valid) begin
         thr_ff <= csr_det_threshold;
      end
   end

   // pipeline moves unless both output slots are full and stalled
   assign adv       = !skid_vld_ff || !rsp_stall;
   assign req_stall = !adv;
   assign incoming  = adv && vld_ff[PIPE_STAGES];
   assign pop       = out_vld_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= PIPE_STAGES; k++) vld_ff[k] <= 1'b0;
      end else if (adv) begin
         vld_ff[1] <= req_valid;
         for (int k = 2; k <= PIPE_STAGES; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   assign a_in[0] = req_a00;
   assign a_in[1] = req_a01;
   assign a_in[2] = req_a02;
   assign a_in[3] = req_a10;
   assign a_in[4] = req_a11;
   assign a_in[5] = req_a12;
   assign a_in[6] = req_a20;
   assign a_in[7] = req_a21;
   assign a_in[8] = req_a22;

   // cofactors and determinant
   mi3_det u_det (
      .clock        (clock),
      .adv          (adv),
      .a_in         (a_in),
      .threshold    (thr_ff),
      .adj_out      (adj_w),
      .det_out      (det_w),
      .singular_out (det_sing)
   );

   // one divider lane per matrix element
   for (genvar j = 0; j < N_ELEM; j++) begin : g_lane
      mi3_lane u_lane (
         .clock   (clock),
         .adv     (adv),
         .adj_in  (adj_w[j]),
         .det_in  (det_w),
         .res_out (lane_res[j])
      );
   end

   // singular flag rides alongside the lanes
   always_ff @(posedge clock) begin
      if (adv) begin
         sing_ff[DET_STAGES+2] <= det_sing;
         for (int k = DET_STAGES + 3; k <= PIPE_STAGES; k++) sing_ff[k] <= sing_ff[k-1];
      end
   end

   // merge: sign, saturation, identity on singular
   always_comb begin
      for (int j = 0; j < N_ELEM; j++) begin
         if (sing_ff[PIPE_STAGES]) begin
            fin_b[j] = (j % 4 == 0) ? ONE_Q16 : '0;
         end else if (lane_res[j].neg) begin
            fin_b[j] = (lane_res[j].ovf || lane_res[j].quo > SAT_NEG) ?
                       SAT_NEG : '0 - lane_res[j].quo;
         end else begin
            fin_b[j] = (lane_res[j].ovf || lane_res[j].quo[Q_W-1]) ?
                       SAT_POS : lane_res[j].quo;
         end
      end
   end

   // output register and skid entry control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (pop) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= incoming;
         end
      end else if (!out_vld_ff || pop) begin
         out_vld_ff <= incoming;
      end else if (incoming) begin
         skid_vld_ff <= 1'b1;
      end
   end

   // output register and skid entry payload
   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (pop) begin
            out_b_ff     <= skid_b_ff;
            out_sing_ff  <= skid_sing_ff;
            skid_b_ff    <= fin_b;
            skid_sing_ff <= sing_ff[PIPE_STAGES];
         end
      end else if (!out_vld_ff || pop) begin
         out_b_ff    <= fin_b;
         out_sing_ff <= sing_ff[PIPE_STAGES];
      end else if (incoming) begin
         skid_b_ff    <= fin_b;
         skid_sing_ff <= sing_ff[PIPE_STAGES];
      end
   end

   assign rsp_valid    = out_vld_ff;
   assign rsp_singular = out_sing_ff;
   assign rsp_b00      = out_b_ff[0];
   assign rsp_b01      = out_b_ff[1];
   assign rsp_b02      = out_b_ff[2];
   assign rsp_b10      = out_b_ff[3];
   assign rsp_b11      = out_b_ff[4];
   assign rsp_b12      = out_b_ff[5];
   assign rsp_b20      = out_b_ff[6];
   assign rsp_b21      = out_b_ff[7];
   assign rsp_b22      = out_b_ff[8];

endmodule

// File: hdl/mi3_checker.sv
module mi3_checker import mi3_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic signed [Q_W-1:0] rsp_b00,
   input logic signed [Q_W-1:0] rsp_b01,
   input logic signed [Q_W-1:0] rsp_b11,
   input logic signed [Q_W-1:0] rsp_b22,
   input logic                  rsp_singular
);

   // nothing left to deliver after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a held beat stays valid and keeps b00 and its singular flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_b00) && $stable(rsp_singular))
      else $error("stalled rsp beat changed");

   // input only backs up when the output side is full and stalled
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without rsp backpressure");

   // singular beats carry the identity diagonal and a zero b01
   a_identity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_b00 == ONE_Q16 && rsp_b11 == ONE_Q16 &&
                                    rsp_b22 == ONE_Q16 && rsp_b01 == '0)
      else $error("singular beat is not the identity");

endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_b00      (rsp_b00),
   .rsp_b01      (rsp_b01),
   .rsp_b11      (rsp_b11),
   .rsp_b22      (rsp_b22),
   .rsp_singular (rsp_singular)
);

// File: sim/tb_matrix_inverse_3x3.sv
module tb_matrix_inverse_3x3;
   import mi3_pkg::*;

   typedef logic signed [127:0] wide_type;
   typedef elem_type mat_type [N_ELEM];
   typedef struct {
      logic [Q_W-1:0] b [N_ELEM];
      logic           singular;
   } inverse_type;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_WAIT  = PIPE_STAGES + 20;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   elem_type req_a [N_ELEM];
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [Q_W-1:0] rsp_b [N_ELEM];
   logic rsp_singular;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [THR_W-1:0] csr_det_threshold = '0;

   inverse_type expected_inverses [$];
   logic [THR_W-1:0] threshold_model;
   int error_count = 0;
   int cycle_count = 0;
   int stall_left = 0;
   bit stall_enable = 1'b1;
   bit gap_enable = 1'b1;

   initial begin
      for (int i = 0; i < N_ELEM; i++) req_a[i] = '0;
   end

   always #6 clock = ~clock;

   matrix_inverse_3x3 u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_a00(req_a[0]), .req_a01(req_a[1]), .req_a02(req_a[2]),
      .req_a10(req_a[3]), .req_a11(req_a[4]), .req_a12(req_a[5]),
      .req_a20(req_a[6]), .req_a21(req_a[7]), .req_a22(req_a[8]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_b00(rsp_b[0]), .rsp_b01(rsp_b[1]), .rsp_b02(rsp_b[2]),
      .rsp_b10(rsp_b[3]), .rsp_b11(rsp_b[4]), .rsp_b12(rsp_b[5]),
      .rsp_b20(rsp_b[6]), .rsp_b21(rsp_b[7]), .rsp_b22(rsp_b[8]),
      .rsp_singular(rsp_singular),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_det_threshold(csr_det_threshold)
   );

   // quotient rounded half away from zero, then signed and saturated
   function automatic logic [Q_W-1:0] scaled_quotient(wide_type adj, logic [127:0] dmag,
                                                      logic dneg);
      logic [127:0] mag;
      logic [127:0] q;
      logic neg;
      neg = adj[127] ^ dneg;
      mag = adj[127] ? -adj : adj;
      q = ((mag << 33) + dmag) / (dmag << 1);
      if (neg) begin
         if (q > 128'h8000_0000) return SAT_NEG;
         return -q[Q_W-1:0];
      end
      if (q > 128'h7FFF_FFFF) return SAT_POS;
      return q[Q_W-1:0];
   endfunction

   // exact adjugate and determinant, identity when below threshold
   function automatic inverse_type invert_matrix(mat_type m, logic [THR_W-1:0] thr);
      wide_type a [N_ELEM];
      wide_type adj [N_ELEM];
      wide_type det;
      logic [127:0] dmag;
      inverse_type r;
      for (int i = 0; i < N_ELEM; i++) a[i] = wide_type'(m[i]);
      adj[0] = a[4] * a[8] - a[7] * a[5];
      adj[3] = a[6] * a[5] - a[3] * a[8];
      adj[6] = a[3] * a[7] - a[6] * a[4];
      adj[1] = a[7] * a[2] - a[1] * a[8];
      adj[4] = a[0] * a[8] - a[6] * a[2];
      adj[7] = a[6] * a[1] - a[0] * a[7];
      adj[2] = a[1] * a[5] - a[4] * a[2];
      adj[5] = a[3] * a[2] - a[0] * a[5];
      adj[8] = a[0] * a[4] - a[3] * a[1];
      det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
      dmag = det[127] ? -det : det;
      if (dmag == 0 || dmag < ({112'd0, thr} << 32)) begin
         for (int i = 0; i < N_ELEM; i++) r.b[i] = (i % 4 == 0) ? ONE_Q16 : '0;
         r.singular = 1'b1;
      end else begin
         for (int i = 0; i < N_ELEM; i++) r.b[i] = scaled_quotient(adj[i], dmag, det[127]);
         r.singular = 1'b0;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [Q_W-1:0] got, logic [Q_W-1:0] want);
      error_count++;
      $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
   endtask

   // accepted beats on every channel: predict, check, track threshold
   always @(posedge clock) begin
      inverse_type want;
      mat_type m;
      if (reset) begin
         threshold_model <= 16'd1;
      end else begin
         if (csr_valid && csr_ready) threshold_model <= csr_det_threshold;
         if (req_valid && !req_stall) begin
            for (int i = 0; i < N_ELEM; i++) m[i] = req_a[i];
            expected_inverses.push_back(invert_matrix(m, threshold_model));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_inverses.size() == 0) begin
               report_mismatch("unexpected beat", rsp_b[0], '0);
            end else begin
               want = expected_inverses.pop_front();
               for (int i = 0; i < N_ELEM; i++)
                  if (rsp_b[i] !== want.b[i])
                     report_mismatch($sformatf("b%0d%0d", i / 3, i % 3), rsp_b[i], want.b[i]);
               if (rsp_singular !== want.singular)
                  report_mismatch("singular", Q_W'(rsp_singular), Q_W'(want.singular));
            end
         end
      end
   end

   // receiver stalls, redrawn after each accepted beat
   always @(posedge clock) begin
      int next;
      next = stall_left;
      if (next > 0) next--;
      if (!reset && rsp_valid && !rsp_stall)
         next = stall_enable ? (($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0) : 0;
      if (!stall_enable) next = 0;
      stall_left <= next;
      rsp_stall <= (next > 0);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_matrix_inverse_3x3: errors");
         $finish;
      end
   end

   task automatic send_matrix(mat_type m);
      int gap;
      gap = gap_enable ? (($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      for (int i = 0; i < N_ELEM; i++) req_a[i] <= m[i];
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_inverses.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_threshold(logic [THR_W-1:0] thr);
      wait_drained();
      csr_valid <= 1'b1;
      csr_det_threshold <= thr;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic mat_type diag_matrix(elem_type d0, elem_type d1, elem_type d2);
      mat_type m;
      for (int i = 0; i < N_ELEM; i++) m[i] = '0;
      m[0] = d0;
      m[4] = d1;
      m[8] = d2;
      return m;
   endfunction

   function automatic mat_type fill_matrix(elem_type v);
      mat_type m;
      for (int i = 0; i < N_ELEM; i++) m[i] = v;
      return m;
   endfunction

   // random matrix in one of several flavors
   function automatic mat_type random_matrix();
      mat_type m;
      int kind;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < N_ELEM; i++) begin
         case (kind) inside
            [0:1]: m[i] = $urandom;
            2: m[i] = $signed($urandom_range(0, 32'h0000_FFFF)) - 32'sh8000;
            3: m[i] = $signed($urandom_range(0, 32'h0000_0FFF)) - 32'sh0800;
            default: m[i] = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
         endcase
      end
      // dependent rows: row 2 from rows 0 and 1, nearly singular
      if (kind == 4) begin
         for (int c = 0; c < 3; c++) m[6 + c] = m[c] + m[3 + c] + $signed($urandom_range(0, 3));
      end
      if (kind == 5) m = diag_matrix($urandom_range(1, 300), $urandom_range(1, 300),
                                     $urandom_range(1, 65536));
      return m;
   endfunction

   task automatic test_directed();
      mat_type m;
      send_matrix(diag_matrix(ONE_Q16, ONE_Q16, ONE_Q16));
      send_matrix(fill_matrix('0));
      send_matrix(fill_matrix(32'sh7FFF_FFFF));
      send_matrix(fill_matrix(-32'sh8000_0000));
      send_matrix(diag_matrix(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
      send_matrix(diag_matrix(-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000));
      send_matrix(diag_matrix(-32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh0001_0000));
      send_matrix(diag_matrix(32'sh0002_0000, -32'sh0004_0000, 32'sh0000_8000));
      // tiny pivot: saturates both ways
      send_matrix(diag_matrix(32'sd1, ONE_Q16, ONE_Q16));
      send_matrix(diag_matrix(-32'sd1, ONE_Q16, ONE_Q16));
      send_matrix(diag_matrix(32'sd1, 32'sd1, 32'sd1));
      // rounding: 1/3 and 2/3 style quotients
      send_matrix(diag_matrix(32'sh0003_0000, -32'sh0003_0000, 32'sh0000_0003));
      send_matrix(diag_matrix(32'sd2, 32'sh0001_0000, 32'sh0000_8000));
      // permutation and a full rank mixed-sign matrix
      m = fill_matrix('0);
      m[1] = ONE_Q16; m[5] = -32'sh0001_0000; m[6] = ONE_Q16;
      send_matrix(m);
      m = '{32'sh0002_0000, -32'sh0001_0000, 32'sh0000_0000,
            -32'sh0001_0000, 32'sh0002_0000, -32'sh0001_0000,
            32'sh0000_0000, -32'sh0001_0000, 32'sh0002_0000};
      send_matrix(m);
      // rank one matrix: zero determinant
      m = '{32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
            32'sh0002_0000, 32'sh0004_0000, 32'sh0006_0000,
            -32'sh0001_0000, -32'sh0002_0000, -32'sh0003_0000};
      send_matrix(m);
      send_matrix(fill_matrix(32'sh5555_5555));
      send_matrix(fill_matrix(-32'sh5555_5556));
   endtask

   task automatic test_threshold_settings();
      // zero threshold: only an exactly zero det is singular
      write_threshold(16'd0);
      send_matrix(fill_matrix('0));
      send_matrix(diag_matrix(32'sd1, 32'sd1, 32'sd1));
      send_matrix(diag_matrix(ONE_Q16, ONE_Q16, 32'sd1));
      // largest threshold: det just below and at the limit
      write_threshold(16'hFFFF);
      send_matrix(diag_matrix(ONE_Q16, ONE_Q16, 32'sh0000_FFFE));
      send_matrix(diag_matrix(ONE_Q16, ONE_Q16, 32'sh0000_FFFF));
      send_matrix(diag_matrix(ONE_Q16, -32'sh0001_0000, 32'sh0001_0000));
      write_threshold(16'd1);
      send_matrix(diag_matrix(ONE_Q16, ONE_Q16, 32'sd1));
      send_matrix(diag_matrix(32'sh0000_8000, 32'sh0000_8000, 32'sd2));
   endtask

   task automatic test_random_matrices(int count);
      for (int n = 0; n < count; n++) begin
         if (n % 100 == 50) begin
            case ($urandom_range(0, 3))
               0: write_threshold(16'd0);
               1: write_threshold(16'hFFFF);
               2: write_threshold(16'd1);
               default: write_threshold(THR_W'($urandom_range(0, 16'hFFFF)));
            endcase
         end
         // stretches at full rate on the input side, the output side, or both
         if (n % 100 == 0) begin
            gap_enable = (n % 200 != 0);
            stall_enable = (n % 300 != 0);
         end
         send_matrix(random_matrix());
      end
      gap_enable = 1'b1;
      stall_enable = 1'b1;
   endtask

   task automatic test_drained_pause();
      send_matrix(random_matrix());
      send_matrix(random_matrix());
      wait_drained();
      send_matrix(random_matrix());
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_threshold_settings();
      test_drained_pause();
      test_random_matrices(780);
      wait_drained();
      if (error_count == 0) begin
         $display("tb_matrix_inverse_3x3: clean");
      end else begin
         $display("tb_matrix_inverse_3x3: errors");
      end
      $finish;
   end

endmodule
